### hdl/dbq_pkg.sv
// Package for the decimating biquad filter: state and accumulator codes,
// register indexes, field widths and reset values.
// No dependencies.
package dbq_pkg;

    localparam int COEF_W   = 16;
    localparam int SAMPLE_W = 8;
    localparam int TICK_W   = 8;
    localparam int ACC_W    = 32;
    localparam int IDX_W    = 3;
    localparam int X_SHIFT  = 14;
    // scale_down: (acc << 2) >> 16, low 16 bits = acc[29:14]
    localparam int SCALE_LO = 14;

    localparam logic [IDX_W-1:0] REG_A1    = 3'd0;
    localparam logic [IDX_W-1:0] REG_A2    = 3'd1;
    localparam logic [IDX_W-1:0] REG_B0    = 3'd2;
    localparam logic [IDX_W-1:0] REG_B1    = 3'd3;
    localparam logic [IDX_W-1:0] REG_B2    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DECIM = 3'd5;

    localparam logic signed [COEF_W-1:0] RST_A1 = -16'sd25575;
    localparam logic signed [COEF_W-1:0] RST_A2 = 16'sd10508;
    localparam logic signed [COEF_W-1:0] RST_B0 = 16'sd329;
    localparam logic signed [COEF_W-1:0] RST_B1 = 16'sd658;
    localparam logic signed [COEF_W-1:0] RST_B2 = 16'sd329;
    localparam logic [TICK_W-1:0]        RST_DECIM = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_ACC_W0,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_ACC_Y,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctrl;

endpackage

### hdl/dbq_mac.sv
// Shared multiply-accumulate unit: one 16x16 signed multiplier with a
// registered product and a 32-bit wrapping accumulator. Uses dbq_pkg.
module dbq_mac
    import dbq_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic signed [COEF_W-1:0] i_opnd,
    input  logic [ACC_W-1:0]         i_x,
    output logic [ACC_W-1:0]         o_acc
);

    logic signed [ACC_W-1:0] r_prod;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_opnd;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        case (i_ctrl.acc_op)
            ACC_LOAD_X: n_acc = i_x;
            ACC_LOAD_P: n_acc = r_prod;
            ACC_ADD:    n_acc = r_acc + r_prod;
            ACC_SUB:    n_acc = r_acc - r_prod;
            default:    n_acc = r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

### hdl/decimating_biquad_filter.sv
// Decimating direct-form-II biquad: tick counter, sequencer and one shared MAC.
// A filter tick runs the sequencer from ST_MUL_A1 through ST_OUT, and the
// input stalls until it returns to ST_IDLE, which a held result that stalls
// the output can delay; on other ticks the sequencer stays idle.
// The five products go through one multiplier in sequence.
// Reset (synchronous, active low) restores coefficient defaults and clears
// the tick counter, the two delays and the output valid.
module decimating_biquad_filter
    import dbq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_W-1:0]      i_sample,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [COEF_W-1:0] o_filtered,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    // coefficient and decimation registers
    logic signed [COEF_W-1:0] r_a1, r_a2, r_b0, r_b1, r_b2;
    logic [TICK_W-1:0]        r_decim;

    // filter state
    logic [TICK_W-1:0]        r_tick_count;
    logic signed [COEF_W-1:0] r_delay_one, r_delay_two, r_w0;
    logic [ACC_W-1:0]         r_x;

    t_state r_state, n_state;

    // output register
    logic                     r_out_valid;
    logic signed [COEF_W-1:0] r_filtered;

    // sequencer outputs
    t_mac_ctrl                mac_ctrl;
    logic signed [COEF_W-1:0] mac_coef, mac_opnd;
    logic [ACC_W-1:0]         acc;
    logic signed [COEF_W-1:0] acc_scaled;

    logic                     in_accept;
    logic [TICK_W-1:0]        tick_inc;
    logic                     tick_match;
    logic                     out_free;
    logic                     out_load;

    assign o_cfg_ready = 1'b1;   // user must send writes only while idle; the block does not enforce it
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign tick_inc    = r_tick_count + 8'd1;  // wraps 255 -> 0
    assign tick_match  = (tick_inc == r_decim);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == ST_OUT) && out_free;
    assign acc_scaled  = acc[SCALE_LO +: COEF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1    <= RST_A1;
            r_a2    <= RST_A2;
            r_b0    <= RST_B0;
            r_b1    <= RST_B1;
            r_b2    <= RST_B2;
            r_decim <= RST_DECIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_A1:    r_a1    <= i_cfg_data;
                REG_A2:    r_a2    <= i_cfg_data;
                REG_B0:    r_b0    <= i_cfg_data;
                REG_B1:    r_b1    <= i_cfg_data;
                REG_B2:    r_b2    <= i_cfg_data;
                REG_DECIM: r_decim <= i_cfg_data[TICK_W-1:0];
                default:   ;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tick_count <= '0;
            r_delay_one  <= '0;
            r_delay_two  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_tick_count <= tick_match ? '0 : tick_inc;
            end
            if (out_load) begin
                r_delay_two <= r_delay_one;
                r_delay_one <= r_w0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x <= {{(ACC_W-SAMPLE_W-X_SHIFT){1'b0}}, i_sample, {X_SHIFT{1'b0}}};
        end
        if (r_state == ST_MUL_B0) begin
            r_w0 <= acc_scaled;
        end
        if (out_load) begin
            r_filtered <= acc_scaled;
        end
    end

    // next state
    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = (in_accept && tick_match) ? ST_MUL_A1 : ST_IDLE;
            ST_MUL_A1: n_state = ST_MUL_A2;
            ST_MUL_A2: n_state = ST_ACC_W0;
            ST_ACC_W0: n_state = ST_MUL_B0;
            ST_MUL_B0: n_state = ST_MUL_B1;
            ST_MUL_B1: n_state = ST_MUL_B2;
            ST_MUL_B2: n_state = ST_ACC_Y;
            ST_ACC_Y:  n_state = ST_OUT;
            ST_OUT:    n_state = out_free ? ST_IDLE : ST_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: product is registered, so each accumulate
    // uses its product in the cycle after the multiply
    always_comb begin
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
        mac_coef        = r_a1;
        mac_opnd        = r_delay_one;
        case (r_state)
            ST_MUL_A1: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_LOAD_X;
            end
            ST_MUL_A2: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_SUB;
                mac_coef        = r_a2;
                mac_opnd        = r_delay_two;
            end
            ST_ACC_W0: begin
                mac_ctrl.acc_op = ACC_SUB;
            end
            ST_MUL_B0: begin
                // accumulator now holds the new delay value
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = r_b0;
                mac_opnd        = acc_scaled;
            end
            ST_MUL_B1: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_LOAD_P;
                mac_coef        = r_b1;
            end
            ST_MUL_B2: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_ADD;
                mac_coef        = r_b2;
                mac_opnd        = r_delay_two;
            end
            ST_ACC_Y: begin
                mac_ctrl.acc_op = ACC_ADD;
            end
            default: ;
        endcase
    end

    dbq_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_coef (mac_coef),
        .i_opnd (mac_opnd),
        .i_x    (r_x),
        .o_acc  (acc)
    );

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    // a tick that misses the decimation setting leaves the sequencer idle
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !tick_match) |=> (r_state == ST_IDLE))
        else $error("filter started on a non-matching tick");

    // counter is cleared by the time the update runs
    a_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_A1) |-> (r_tick_count == '0))
        else $error("tick counter not cleared at filter start");

    // delays move only when a result is loaded
    a_delay_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> ($stable(r_delay_one) && $stable(r_delay_two)))
        else $error("delay changed outside result load");

    // leaving the output state always presents a result
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && n_state == ST_IDLE) |=> r_out_valid)
        else $error("result lost on leaving output state");

endmodule
